// ===== design/bounded_deque_with_remove_macros.svh =====
// Assertion helpers for the deque top level.
`ifndef BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bdq_pkg.sv =====
`default_nettype none
package bdq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W     = 32;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int FILL_W     = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REMOVE     = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic take_left;    // push front: every cell loads its left neighbor
    logic load_tail;    // push back: the cell at the fill position loads the value
    logic take_right;   // pop front: every cell loads its right neighbor
    logic remove_shift; // remove: cells at or behind the first hit load right neighbor
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/bdq_cell.sv =====
`default_nettype none
module bdq_cell
  import bdq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [CNT_W-1:0]  occ,
  input  wire logic [DATA_W-1:0] value,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  input  wire logic              hit_in,
  output logic                   hit_out,
  output logic [DATA_W-1:0]      data
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              held;
  logic              at_tail;

  assign held    = CNT_W'(IDX) < occ;
  assign at_tail = CNT_W'(IDX) == occ;
  // The hit chain marks this cell and everything behind the first match.
  assign hit_out = hit_in | (held & (data_r == value));
  assign data    = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.take_left) begin
      data_nxt = left_data;
    end else if (ctl.take_right || (ctl.remove_shift && hit_out)) begin
      data_nxt = right_data;
    end else if (ctl.load_tail && at_tail) begin
      data_nxt = value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

// ===== design/bounded_deque_with_remove.sv =====
// A result item is registered and appears in the cycle after its request item is accepted.
// Throughput: one item per cycle; the request is taken whenever the output
// register is empty or being drained in the same cycle.
// The longest path is the match chain that ripples through all DEPTH cells.
// Reset (rst_n low, synchronous) empties the queue and clears the output valid.
`default_nettype none
`include "bounded_deque_with_remove_macros.svh"
module bounded_deque_with_remove
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // in_tdata: [2:0] mode, [34:3] value, [39:35] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_tdata: [1:0] status, [33:2] taken_value, [38:34] fill_count, [39] zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Queue occupancy; position 0 is the front.
  logic [CNT_W-1:0]  occ_r;
  logic [CNT_W-1:0]  occ_nxt;

  // Output register holding one finished result.
  logic              out_valid_r;
  status_t           status_r;
  status_t           status_nxt;
  logic [DATA_W-1:0] taken_r;
  logic [DATA_W-1:0] taken_nxt;

  logic [MODE_W-1:0] mode;
  logic [DATA_W-1:0] value;
  logic              accept;
  logic              full;
  logic              empty;
  logic              found;
  cell_ctl_t         ctl;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] left_data [DEPTH];
  logic [DATA_W-1:0] right_data [DEPTH];
  logic [DEPTH:0]    hit;
  logic [31:0]       occ_ext;
  logic [IDX_W-1:0]  tail_idx;

  assign mode      = in_tdata[MODE_W-1:0];
  assign value     = in_tdata[MODE_W +: DATA_W];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = occ_r == CNT_W'(DEPTH);
  assign empty     = occ_r == '0;
  assign found     = hit[DEPTH];
  assign tail_idx  = IDX_W'(occ_r - CNT_W'(1));
  assign hit[0]    = 1'b0;

  // Each cell sees its neighbors; the front cell's left input is the pushed
  // value, and the last cell simply holds on a shift toward the front.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_front
      assign left_data[g] = value;
    end else begin : g_mid
      assign left_data[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_back
      assign right_data[g] = cell_data[g];
    end else begin : g_inner
      assign right_data[g] = cell_data[g+1];
    end

    bdq_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ_r),
      .value      (value),
      .left_data  (left_data[g]),
      .right_data (right_data[g]),
      .hit_in     (hit[g]),
      .hit_out    (hit[g+1]),
      .data       (cell_data[g])
    );
  end

  // Decode the request into a cell command, the new count and the result.
  always_comb begin
    ctl        = '0;
    occ_nxt    = occ_r;
    status_nxt = ST_OK;
    taken_nxt  = '0;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.take_left = accept;
          occ_nxt       = occ_r + CNT_W'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.load_tail = accept;
          occ_nxt       = occ_r + CNT_W'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.take_right = accept;
          taken_nxt      = cell_data[0];
          occ_nxt        = occ_r - CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          taken_nxt = cell_data[tail_idx];
          occ_nxt   = occ_r - CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        // A hit means the stored entry equals the search value, so the
        // removed value is the search value itself.
        if (found) begin
          ctl.remove_shift = accept;
          taken_nxt        = value;
          occ_nxt          = occ_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      default: begin
        // Unused request codes leave the queue as it is.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      taken_r  <= taken_nxt;
    end
  end

  // The result's count is the current occupancy, which changes only when a
  // new item is taken and the output register is reloaded with it.
  assign occ_ext    = 32'(occ_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, occ_ext[FILL_W-1:0], taken_r, status_r};

  `BDQ_ASSERT_IMPL(a_occ_bound, 1'b1, occ_r <= CNT_W'(DEPTH), "occupancy beyond depth")
  `BDQ_ASSERT_NEXT(a_accept_valid, accept, out_valid_r, "accepted item produced no result")
  `BDQ_ASSERT_IMPL(a_full_count, out_valid_r && status_r == ST_FULL,
                   occ_r == CNT_W'(DEPTH), "full status with room left")
  `BDQ_ASSERT_IMPL(a_empty_zero, out_valid_r && status_r == ST_EMPTY,
                   occ_r == '0 && taken_r == '0, "empty status with entries or a value")
  `BDQ_ASSERT_NEXT(a_pop_count, accept && mode == MODE_POP_FRONT && !empty,
                   occ_r == $past(occ_r) - CNT_W'(1), "pop did not lower the count")

endmodule
`default_nettype wire
